>>> hw/rtl/can_rx_pkg.sv
// Shared types and constants of the CAN receive slot pool.
// Holds the action codes, the field widths and the layout of one stored slot.
// No dependencies.
package can_rx_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int ID_W           = 29;
	localparam int LEN_W          = 4;
	localparam int DATA_W         = 64;
	localparam int PORT_W         = 2;
	localparam int IDX_W          = 8;
	localparam int MAX_LEN        = 8;

	typedef enum logic [2:0] {
		ACT_STORE   = 3'd0,
		ACT_FETCH   = 3'd1,
		ACT_DONE    = 3'd2,
		ACT_RELEASE = 3'd3,
		ACT_READ    = 3'd4
	} action_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              ext;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic [PORT_W-1:0] port;
	} slot_entry_t;

endpackage

>>> hw/rtl/can_rx_slot_pool.sv
// Top level of the CAN receive slot pool: flags, pointers, slot memory and control.
// Depends on can_rx_pkg.
//
// Usage: one input transaction carries an action (store, fetch next pending,
// mark done, release, read) with the frame fields; each one yields exactly one
// output transaction with ok, the slot index and the slot contents after the action.
// The input channel takes a transaction in the idle cycle; in that cycle a
// rotated priority search over the occupied and done flag registers picks the
// slot and the slot memory is read. In the write-back state the block merges the
// read data, writes the slot back and loads the output register; it takes no
// new transaction until that write-back is done, since each item reads the slot
// memory and then writes it back.
// The output register keeps a finished result while the receiver stalls; the
// next input is still taken and waits in the write-back state until the output
// register is free.
// Reset clears all flags, both pointers and the written mark of every slot, so
// that slots never written read as zero; no clearing pass is needed.
module can_rx_slot_pool
	import can_rx_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [IDX_W-1:0]  slot,
	input  logic [ID_W-1:0]   frame_id,
	input  logic              is_extended,
	input  logic [LEN_W-1:0]  length,
	input  logic [DATA_W-1:0] payload,
	input  logic [PORT_W-1:0] port,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic [IDX_W-1:0]  slot_index,
	output logic [ID_W-1:0]   out_id,
	output logic              out_extended,
	output logic [LEN_W-1:0]  out_length,
	output logic [DATA_W-1:0] out_payload,
	output logic [PORT_W-1:0] out_port,
	output logic              out_occupied,
	output logic              out_done
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W:0] COUNT_L = (SLOT_W+1)'(SLOT_COUNT);

	typedef enum logic {ST_IDLE, ST_WB} state_t;

	state_t                  state_q;
	logic [SLOT_COUNT-1:0]   occ_q;
	logic [SLOT_COUNT-1:0]   done_q;
	logic [SLOT_COUNT-1:0]   written_q;
	logic [SLOT_W-1:0]       wp_q;
	logic [SLOT_W-1:0]       rp_q;

	slot_entry_t             mem [SLOT_COUNT];
	slot_entry_t             mem_rd_s1;

	action_t                 act_s1;
	logic                    hit_s1;
	logic [SLOT_W-1:0]       idx_s1;
	logic [ID_W-1:0]         id_s1;
	logic                    ext_s1;
	logic [LEN_W-1:0]        len_s1;
	logic [DATA_W-1:0]       data_s1;
	logic [PORT_W-1:0]       port_s1;
	logic                    occ_s1;
	logic                    done_s1;
	logic                    rd_vld_s1;

	logic                    free_found;
	logic [SLOT_W-1:0]       free_idx;
	logic                    pend_found;
	logic [SLOT_W-1:0]       pend_idx;
	logic [SLOT_W:0]         cand_w;
	logic [SLOT_W:0]         cand_r;
	logic                    slot_in_range;
	logic                    tgt_hit;
	logic [SLOT_W-1:0]       tgt_idx;
	logic [LEN_W-1:0]        len_sat;
	logic                    in_fire;
	logic                    wb_fire;

	slot_entry_t             old_entry;
	slot_entry_t             new_entry;
	logic                    new_occ;
	logic                    new_done;
	logic                    mem_we;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign wb_fire  = (state_q == ST_WB) && (!out_valid || out_ready);

	always_comb begin
		free_found = 1'b0;
		free_idx   = wp_q;
		pend_found = 1'b0;
		pend_idx   = rp_q;
		cand_w     = '0;
		cand_r     = '0;
		for (int k = 1; k <= SLOT_COUNT; k++) begin
			cand_w = {1'b0, wp_q} + (SLOT_W+1)'(k);
			if (cand_w >= COUNT_L) begin
				cand_w = cand_w - COUNT_L;
			end
			if (!free_found && !occ_q[cand_w[SLOT_W-1:0]]) begin
				free_found = 1'b1;
				free_idx   = cand_w[SLOT_W-1:0];
			end
			cand_r = {1'b0, rp_q} + (SLOT_W+1)'(k);
			if (cand_r >= COUNT_L) begin
				cand_r = cand_r - COUNT_L;
			end
			if (!pend_found && occ_q[cand_r[SLOT_W-1:0]] && !done_q[cand_r[SLOT_W-1:0]]) begin
				pend_found = 1'b1;
				pend_idx   = cand_r[SLOT_W-1:0];
			end
		end
	end

	always_comb begin
		slot_in_range = ({1'b0, slot} < (IDX_W+1)'(SLOT_COUNT));
		len_sat = (length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length;
		case (action_t'(action))
			ACT_STORE: begin
				tgt_hit = free_found;
				tgt_idx = free_idx;
			end
			ACT_FETCH: begin
				tgt_hit = pend_found;
				tgt_idx = pend_idx;
			end
			ACT_DONE, ACT_RELEASE, ACT_READ: begin
				tgt_hit = slot_in_range;
				tgt_idx = slot[SLOT_W-1:0];
			end
			default: begin
				tgt_hit = 1'b0;
				tgt_idx = slot[SLOT_W-1:0];
			end
		endcase
	end

	always_comb begin
		old_entry = rd_vld_s1 ? mem_rd_s1 : '0;
		new_entry = old_entry;
		new_occ   = occ_s1;
		new_done  = done_s1;
		mem_we    = 1'b0;
		case (act_s1)
			ACT_STORE: begin
				new_entry.id   = id_s1;
				new_entry.ext  = ext_s1;
				new_entry.len  = len_s1;
				new_entry.port = port_s1;
				for (int b = 0; b < MAX_LEN; b++) begin
					if (LEN_W'(b) < len_s1) begin
						new_entry.data[b*8 +: 8] = data_s1[b*8 +: 8];
					end
				end
				new_occ  = 1'b1;
				new_done = 1'b0;
				mem_we   = hit_s1;
			end
			ACT_DONE: begin
				new_done = 1'b1;
			end
			ACT_RELEASE: begin
				new_entry.id   = '0;
				new_entry.port = '0;
				new_occ        = 1'b0;
				new_done       = 1'b0;
				mem_we         = hit_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wb_fire && mem_we) begin
			mem[idx_s1] <= new_entry;
		end
		if (in_fire) begin
			mem_rd_s1 <= mem[tgt_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			done_q       <= '0;
			written_q    <= '0;
			wp_q         <= '0;
			rp_q         <= '0;
			act_s1       <= ACT_READ;
			hit_s1       <= 1'b0;
			idx_s1       <= '0;
			id_s1        <= '0;
			ext_s1       <= 1'b0;
			len_s1       <= '0;
			data_s1      <= '0;
			port_s1      <= '0;
			occ_s1       <= 1'b0;
			done_s1      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_valid    <= 1'b0;
			ok           <= 1'b0;
			slot_index   <= '0;
			out_id       <= '0;
			out_extended <= 1'b0;
			out_length   <= '0;
			out_payload  <= '0;
			out_port     <= '0;
			out_occupied <= 1'b0;
			out_done     <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						act_s1    <= action_t'(action);
						hit_s1    <= tgt_hit;
						idx_s1    <= tgt_idx;
						id_s1     <= frame_id;
						ext_s1    <= is_extended;
						len_s1    <= len_sat;
						data_s1   <= payload;
						port_s1   <= port;
						occ_s1    <= occ_q[tgt_idx];
						done_s1   <= done_q[tgt_idx];
						rd_vld_s1 <= written_q[tgt_idx];
						if (action_t'(action) == ACT_STORE) begin
							wp_q <= free_idx;
						end
						if (action_t'(action) == ACT_FETCH) begin
							rp_q <= pend_idx;
						end
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_fire) begin
						out_valid <= 1'b1;
						if (hit_s1) begin
							occ_q[idx_s1]  <= new_occ;
							done_q[idx_s1] <= new_done;
							if (mem_we) begin
								written_q[idx_s1] <= 1'b1;
							end
							ok           <= 1'b1;
							slot_index   <= IDX_W'(idx_s1);
							out_id       <= new_entry.id;
							out_extended <= new_entry.ext;
							out_length   <= new_entry.len;
							out_payload  <= new_entry.data;
							out_port     <= new_entry.port;
							out_occupied <= new_occ;
							out_done     <= new_done;
						end else begin
							ok           <= 1'b0;
							slot_index   <= '0;
							out_id       <= '0;
							out_extended <= 1'b0;
							out_length   <= '0;
							out_payload  <= '0;
							out_port     <= '0;
							out_occupied <= 1'b0;
							out_done     <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/can_rx_checker.sv
// Port-level checker of the CAN receive slot pool, with its bind to the top level.
// Depends on can_rx_pkg and can_rx_slot_pool.
module can_rx_checker
	import can_rx_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              ok,
	input logic [IDX_W-1:0]  slot_index,
	input logic [ID_W-1:0]   out_id,
	input logic              out_extended,
	input logic [LEN_W-1:0]  out_length,
	input logic [DATA_W-1:0] out_payload,
	input logic [PORT_W-1:0] out_port,
	input logic              out_occupied,
	input logic              out_done
);

	// A stalled result keeps its contents until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(slot_index)
			&& $stable(out_payload) && $stable(out_id))
		else $error("output transaction changed while stalled");

	// A failed action reports all fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> slot_index == '0 && out_id == '0 && !out_extended
			&& out_length == '0 && out_payload == '0 && out_port == '0
			&& !out_occupied && !out_done)
		else $error("failed action reported nonzero fields");

	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_length <= LEN_W'(MAX_LEN))
		else $error("reported length above eight");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> {1'b0, slot_index} < (IDX_W+1)'(SLOT_COUNT))
		else $error("reported slot index out of range");

	// Each item occupies the block for its write-back state.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item was in progress");

endmodule

bind can_rx_slot_pool can_rx_checker #(.SLOT_COUNT(SLOT_COUNT)) u_can_rx_checker (.*);
